@@ design/pcsb_pkg.sv @@
// Package for the pendulum chain swing-up and balance controller.
// Holds the payload, configuration and command types, the fixed-point constants
// and the quarter-wave sine table. It depends on nothing else.
`default_nettype none

package pcsb_pkg;

   localparam int MAX_POLES        = 32;
   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int ITEM_IDX_W  = $clog2(MAX_POLES + 2);
   localparam int TBL_IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int TBL_QUARTER = SINE_TABLE_DEPTH / 4;
   localparam int QS_ENTRIES  = TBL_QUARTER + 1;
   localparam int QS_W        = 17;

   localparam logic [32:0] INV_TWO_PI_Q32 = 33'd683565276;
   localparam logic [32:0] G_Q16          = 33'd642908;
   localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
   localparam logic [63:0] ONE_Q30        = 64'd1073741824;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic [15:0]        pole_mass;
      logic [15:0]        pole_length;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_res;
      logic               balance_mode;
   } rsp_type;

   typedef struct packed {
      logic [30:0] gain_cart_pos;
      logic [30:0] gain_angle;
      logic [30:0] gain_cart_vel;
      logic [30:0] gain_rate;
      logic [30:0] swing_gain;
      logic [30:0] force_limit;
      logic [17:0] angle_window;
      logic [30:0] cart_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_cart_pos: 31'd327680,
      gain_angle:    31'd13107200,
      gain_cart_vel: 31'd655360,
      gain_rate:     31'd1310720,
      swing_gain:    31'd6553600,
      force_limit:   31'd5242880,
      angle_window:  18'd5243,
      cart_limit:    31'd163840
   };

   typedef enum logic [2:0] {
      CSR_GAIN_CART_POS = 3'd0,
      CSR_GAIN_ANGLE    = 3'd1,
      CSR_GAIN_CART_VEL = 3'd2,
      CSR_GAIN_RATE     = 3'd3,
      CSR_SWING_GAIN    = 3'd4,
      CSR_FORCE_LIMIT   = 3'd5,
      CSR_ANGLE_WINDOW  = 3'd6,
      CSR_CART_LIMIT    = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      MO_POS_INV, MO_M_G, MO_L_C, MO_L_S, MO_LC_VEL, MO_LS_VEL, MO_XD_XD,
      MO_YD_YD, MO_MG_H, MO_SH_M, MO_SL_M, MO_MG_L, MO_GA_POS, MO_GR_VEL,
      MO_VEL_VEL, MO_GCP_POS, MO_GCV_VEL, MO_HI_SW, MO_LO_SW
   } mul_op_type;

   typedef enum logic [4:0] {
      WB_NONE, WB_CART_INIT, WB_CART_ENERGY, WB_FTMP, WB_CART_FB, WB_TRIG,
      WB_MG, WB_LC, WB_LS, WB_HORIZ, WB_VERT, WB_SQ_FIRST, WB_SQ_ADD, WB_PE,
      WB_KH, WB_ENERGY, WB_TARGET, WB_POLE_FB, WB_PH, WB_FORCE
   } wb_op_type;

   typedef struct packed {
      mul_op_type mul_op;
      wb_op_type  wb_op;
      logic       load;
      logic       first_pole;
      logic       out_load;
   } ctl_cmd_type;

   function automatic logic [QS_W-1:0] qs_entry(input int unsigned j);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] q;
      r  = 64'(j) << (32 - TBL_IDX_W);
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      p  = ONE_Q30;
      p  = ONE_Q30 - ((x2 * p) >> 30) / 110;
      p  = ONE_Q30 - ((x2 * p) >> 30) / 72;
      p  = ONE_Q30 - ((x2 * p) >> 30) / 42;
      p  = ONE_Q30 - ((x2 * p) >> 30) / 20;
      p  = ONE_Q30 - ((x2 * p) >> 30) / 6;
      q  = (x * p) >> 30;
      return QS_W'((q + 64'd8192) >> 14);
   endfunction

   function automatic logic [QS_ENTRIES*QS_W-1:0] qs_build();
      logic [QS_ENTRIES*QS_W-1:0] t;
      t = '0;
      for (int j = 0; j < QS_ENTRIES; j++) begin
         t[j*QS_W +: QS_W] = qs_entry(j);
      end
      return t;
   endfunction

   localparam logic [QS_ENTRIES*QS_W-1:0] QS_TABLE = qs_build();

   // Full-turn sine in Q1.16 from the quarter-wave table.
   function automatic logic signed [17:0] sine_at(input logic [TBL_IDX_W-1:0] idx);
      logic [TBL_IDX_W-2:0] j;
      logic [QS_W-1:0]      mag;
      if (idx[TBL_IDX_W-2]) begin
         j = (TBL_IDX_W-1)'(TBL_QUARTER) - {1'b0, idx[TBL_IDX_W-3:0]};
      end else begin
         j = {1'b0, idx[TBL_IDX_W-3:0]};
      end
      mag = QS_TABLE[j*QS_W +: QS_W];
      return idx[TBL_IDX_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -50'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'sd140737488355327) return 48'sh7FFFFFFFFFFF;
      if (v < -50'sd140737488355328) return 48'sh800000000000;
      return v[47:0];
   endfunction

endpackage

`default_nettype wire

@@ design/pcsb_ctrl.sv @@
// Sequencer for the pendulum chain controller: handshakes, item counting and
// the step programme that drives the shared multiplier. Uses pcsb_pkg.
`default_nettype none

module pcsb_ctrl import pcsb_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   input  wire logic  last_item,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CART, ST_POLE, ST_FINAL, ST_OUT
   } state_type;

   localparam logic [3:0] CART_LAST  = 4'd3;
   localparam logic [3:0] POLE_LAST  = 4'd14;
   localparam logic [3:0] FINAL_LAST = 4'd2;

   state_type             state_ff, state_in;
   logic [3:0]            step_ff, step_in;
   logic [ITEM_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      cmd.mul_op     = MO_VEL_VEL;
      cmd.wb_op      = WB_NONE;
      cmd.load       = 1'b0;
      cmd.first_pole = (idx_ff == ITEM_IDX_W'(1));
      cmd.out_load   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = last_item;
               step_in  = '0;
               if (idx_ff == '0) begin
                  state_in = ST_CART;
               end else if (idx_ff <= ITEM_IDX_W'(MAX_POLES)) begin
                  state_in = ST_POLE;
               end else if (last_item) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_CART: begin
            case (step_ff)
               4'd0: begin cmd.mul_op = MO_VEL_VEL; cmd.wb_op = WB_CART_INIT; end
               4'd1: begin cmd.mul_op = MO_GCP_POS; cmd.wb_op = WB_CART_ENERGY; end
               4'd2: begin cmd.mul_op = MO_GCV_VEL; cmd.wb_op = WB_FTMP; end
               default: cmd.wb_op = WB_CART_FB;
            endcase
            if (step_ff == CART_LAST) begin
               step_in  = '0;
               idx_in   = ITEM_IDX_W'(1);
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_POLE: begin
            case (step_ff)
               4'd0:  begin cmd.mul_op = MO_POS_INV; cmd.wb_op = WB_NONE; end
               4'd1:  begin cmd.mul_op = MO_M_G;     cmd.wb_op = WB_TRIG; end
               4'd2:  begin cmd.mul_op = MO_L_C;     cmd.wb_op = WB_MG; end
               4'd3:  begin cmd.mul_op = MO_L_S;     cmd.wb_op = WB_LC; end
               4'd4:  begin cmd.mul_op = MO_LC_VEL;  cmd.wb_op = WB_LS; end
               4'd5:  begin cmd.mul_op = MO_LS_VEL;  cmd.wb_op = WB_HORIZ; end
               4'd6:  begin cmd.mul_op = MO_XD_XD;   cmd.wb_op = WB_VERT; end
               4'd7:  begin cmd.mul_op = MO_YD_YD;   cmd.wb_op = WB_SQ_FIRST; end
               4'd8:  begin cmd.mul_op = MO_MG_H;    cmd.wb_op = WB_SQ_ADD; end
               4'd9:  begin cmd.mul_op = MO_SH_M;    cmd.wb_op = WB_PE; end
               4'd10: begin cmd.mul_op = MO_SL_M;    cmd.wb_op = WB_KH; end
               4'd11: begin cmd.mul_op = MO_MG_L;    cmd.wb_op = WB_ENERGY; end
               4'd12: begin cmd.mul_op = MO_GA_POS;  cmd.wb_op = WB_TARGET; end
               4'd13: begin cmd.mul_op = MO_GR_VEL;  cmd.wb_op = WB_FTMP; end
               default: cmd.wb_op = WB_POLE_FB;
            endcase
            if (step_ff == POLE_LAST) begin
               step_in  = '0;
               idx_in   = idx_ff + ITEM_IDX_W'(1);
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_FINAL: begin
            case (step_ff)
               4'd0:    begin cmd.mul_op = MO_HI_SW; cmd.wb_op = WB_NONE; end
               4'd1:    begin cmd.mul_op = MO_LO_SW; cmd.wb_op = WB_PH; end
               default: cmd.wb_op = WB_FORCE;
            endcase
            if (step_ff == FINAL_LAST) begin
               step_in  = '0;
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/pcsb_datapath.sv @@
// Datapath for the pendulum chain controller: shared multiplier, chain sums,
// sine lookup and the final force selection. Uses pcsb_pkg; driven by pcsb_ctrl.
`default_nettype none

module pcsb_datapath import pcsb_pkg::*; (
   input  wire logic    clock,
   input  wire cfg_type cfg,
   input  wire req_type req_data,
   input  wire ctl_cmd_type cmd,
   output rsp_type      rsp_data
);

   logic signed [31:0] pos_ff, vel_ff;
   logic [15:0]        m_ff, l_ff;
   logic signed [65:0] prod_ff;
   logic signed [17:0] s_ff, c_ff, lc_ff, ls_ff, fpc_ff;
   logic [19:0]        mg_ff;
   logic signed [31:0] cart_speed_ff, horiz_ff, vert_ff, height_ff;
   logic [63:0]        sq_ff;
   logic signed [36:0] pe_ff;
   logic [39:0]        kh_ff;
   logic signed [49:0] ftmp_ff;
   logic signed [47:0] energy_ff, target_ff, feedback_ff;
   logic               upright_ff, centered_ff;
   logic [54:0]        ph_ff;
   rsp_type            res_ff, rsp_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [49:0] p_sh16;
   logic [31:0]        apos;
   logic [47:0]        frac;
   logic [TBL_IDX_W-1:0] sidx, cidx;
   logic signed [17:0] sin_val, cos_val, lc_new;
   logic signed [48:0] de, de_abs, u, lim;
   logic [47:0]        mag;
   logic [63:0]        ke_sum;
   logic [48:0]        swing_sum;
   logic [30:0]        swing_mag;
   logic               neg;
   logic signed [31:0] swing_force, bal_force;
   logic               balance;

   assign rsp_data = rsp_ff;
   assign p_sh16   = prod_ff[65:16];
   assign apos     = pos_ff[31] ? (~pos_ff + 32'd1) : pos_ff;
   assign frac     = prod_ff[47:0];
   assign sidx     = frac[47 -: TBL_IDX_W] + TBL_IDX_W'(frac[47-TBL_IDX_W]);
   assign cidx     = sidx + TBL_IDX_W'(TBL_QUARTER);
   assign sin_val  = sine_at(sidx);
   assign cos_val  = sine_at(cidx);
   assign lc_new   = prod_ff[33:16];

   assign de     = {energy_ff[47], energy_ff} - {target_ff[47], target_ff};
   assign de_abs = de[48] ? -de : de;
   assign mag    = de_abs[47:0];
   assign ke_sum = {kh_ff, 24'b0} + {24'b0, prod_ff[39:0]};

   always_comb begin
      case (cmd.mul_op)
         MO_POS_INV: begin mul_a = {pos_ff[31], pos_ff}; mul_b = INV_TWO_PI_Q32; end
         MO_M_G:     begin mul_a = {17'b0, m_ff}; mul_b = G_Q16; end
         MO_L_C:     begin mul_a = {17'b0, l_ff}; mul_b = {{15{c_ff[17]}}, c_ff}; end
         MO_L_S:     begin mul_a = {17'b0, l_ff}; mul_b = {{15{s_ff[17]}}, s_ff}; end
         MO_LC_VEL:  begin mul_a = {{15{lc_ff[17]}}, lc_ff}; mul_b = {vel_ff[31], vel_ff}; end
         MO_LS_VEL:  begin mul_a = {{15{ls_ff[17]}}, ls_ff}; mul_b = {vel_ff[31], vel_ff}; end
         MO_XD_XD:   begin mul_a = {horiz_ff[31], horiz_ff}; mul_b = {horiz_ff[31], horiz_ff}; end
         MO_YD_YD:   begin mul_a = {vert_ff[31], vert_ff}; mul_b = {vert_ff[31], vert_ff}; end
         MO_MG_H:    begin mul_a = {13'b0, mg_ff}; mul_b = {height_ff[31], height_ff}; end
         MO_SH_M:    begin mul_a = {9'b0, sq_ff[63:40]}; mul_b = {17'b0, m_ff}; end
         MO_SL_M:    begin mul_a = {9'b0, sq_ff[39:16]}; mul_b = {17'b0, m_ff}; end
         MO_MG_L:    begin mul_a = {13'b0, mg_ff}; mul_b = {17'b0, l_ff}; end
         MO_GA_POS:  begin mul_a = {2'b0, cfg.gain_angle}; mul_b = {pos_ff[31], pos_ff}; end
         MO_GR_VEL:  begin mul_a = {2'b0, cfg.gain_rate}; mul_b = {vel_ff[31], vel_ff}; end
         MO_VEL_VEL: begin mul_a = {vel_ff[31], vel_ff}; mul_b = {vel_ff[31], vel_ff}; end
         MO_GCP_POS: begin mul_a = {2'b0, cfg.gain_cart_pos}; mul_b = {pos_ff[31], pos_ff}; end
         MO_GCV_VEL: begin mul_a = {2'b0, cfg.gain_cart_vel}; mul_b = {vel_ff[31], vel_ff}; end
         MO_HI_SW:   begin mul_a = {9'b0, mag[47:24]}; mul_b = {2'b0, cfg.swing_gain}; end
         MO_LO_SW:   begin mul_a = {9'b0, mag[23:0]}; mul_b = {2'b0, cfg.swing_gain}; end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      swing_sum = {1'b0, ph_ff[39:0], 8'b0} + {10'b0, prod_ff[54:16]};
      if ((|ph_ff[54:40]) || (swing_sum > {18'b0, cfg.force_limit})) begin
         swing_mag = cfg.force_limit;
      end else begin
         swing_mag = swing_sum[30:0];
      end
      if (cart_speed_ff == '0) begin
         neg = !fpc_ff[17];
      end else begin
         neg = (fpc_ff[17] != cart_speed_ff[31]) && (fpc_ff != '0);
      end
      if (de[48]) begin
         neg = !neg;
      end
      swing_force = neg ? -$signed({1'b0, swing_mag}) : $signed({1'b0, swing_mag});
      lim = {18'b0, cfg.force_limit};
      u   = -{feedback_ff[47], feedback_ff};
      if (u > lim) begin
         bal_force = lim[31:0];
      end else if (u < -lim) begin
         bal_force = -lim[31:0];
      end else begin
         bal_force = u[31:0];
      end
      balance = upright_ff && centered_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         pos_ff <= req_data.position;
         vel_ff <= req_data.velocity;
         m_ff   <= req_data.pole_mass;
         l_ff   <= req_data.pole_length;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
      case (cmd.wb_op)
         WB_NONE: begin end
         WB_CART_INIT: begin
            cart_speed_ff <= vel_ff;
            horiz_ff      <= vel_ff;
            vert_ff       <= '0;
            height_ff     <= '0;
            target_ff     <= '0;
            fpc_ff        <= '0;
            upright_ff    <= 1'b1;
            centered_ff   <= {apos, 1'b0} < {2'b0, cfg.cart_limit};
         end
         WB_CART_ENERGY: energy_ff <= {1'b0, prod_ff[63:17]};
         WB_FTMP:        ftmp_ff <= p_sh16;
         WB_CART_FB:     feedback_ff <= sat48(ftmp_ff + p_sh16);
         WB_TRIG: begin
            s_ff <= sin_val;
            c_ff <= cos_val;
            if (cmd.first_pole) begin
               fpc_ff <= cos_val;
            end
         end
         WB_MG: mg_ff <= prod_ff[35:16];
         WB_LC: begin
            lc_ff     <= lc_new;
            height_ff <= sat32({{18{height_ff[31]}}, height_ff} - {{32{lc_new[17]}}, lc_new});
         end
         WB_LS:       ls_ff <= prod_ff[33:16];
         WB_HORIZ:    horiz_ff <= sat32({{18{horiz_ff[31]}}, horiz_ff} + p_sh16);
         WB_VERT:     vert_ff <= sat32({{18{vert_ff[31]}}, vert_ff} + p_sh16);
         WB_SQ_FIRST: sq_ff <= prod_ff[63:0];
         WB_SQ_ADD:   sq_ff <= sq_ff + prod_ff[63:0];
         WB_PE:       pe_ff <= p_sh16[36:0];
         WB_KH:       kh_ff <= prod_ff[39:0];
         WB_ENERGY: begin
            energy_ff <= sat48({{2{energy_ff[47]}}, energy_ff} + {3'b0, ke_sum[63:17]}
                               + {{13{pe_ff[36]}}, pe_ff});
         end
         WB_TARGET: target_ff <= sat48({{2{target_ff[47]}}, target_ff} - {30'b0, prod_ff[35:16]});
         WB_POLE_FB: begin
            feedback_ff <= sat48({{2{feedback_ff[47]}}, feedback_ff} + ftmp_ff + p_sh16);
            if (apos > {14'b0, cfg.angle_window}) begin
               upright_ff <= 1'b0;
            end
         end
         WB_PH: ph_ff <= prod_ff[54:0];
         WB_FORCE: begin
            res_ff.force_res    <= balance ? bal_force : swing_force;
            res_ff.balance_mode <= balance;
         end
         default: begin end
      endcase
   end

endmodule

`default_nettype wire

@@ design/pendulum_chain_swingup_balance_ctrl.sv @@
// Top level of the pendulum chain swing-up and balance controller.
// Holds the configuration registers and joins pcsb_ctrl and pcsb_datapath; uses pcsb_pkg.
//
// Each control period is a cart transfer followed by one transfer per pole; the transfer
// that carries last_item yields one result, the saturated cart force and the mode used.
// All products go through a single registered multiplier, which sets the rate: a pole
// transfer runs the pole programme and the cart transfer a shorter cart programme, and
// no new transfer is accepted until that programme is through; a transfer beyond the
// pole limit runs no programme. Ending a period runs the final steps before the result
// is offered. A finished result waits in an output register, so the next period's cart
// item is accepted while it is still held. Configuration writes are taken in any cycle.
`default_nettype none

module pendulum_chain_swingup_balance_ctrl import pcsb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   ctl_cmd_type cmd;

   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index_type'(csr_index))
         CSR_GAIN_CART_POS: cfg_in.gain_cart_pos = csr_wdata;
         CSR_GAIN_ANGLE:    cfg_in.gain_angle    = csr_wdata;
         CSR_GAIN_CART_VEL: cfg_in.gain_cart_vel = csr_wdata;
         CSR_GAIN_RATE:     cfg_in.gain_rate     = csr_wdata;
         CSR_SWING_GAIN:    cfg_in.swing_gain    = csr_wdata;
         CSR_FORCE_LIMIT:   cfg_in.force_limit   = csr_wdata;
         CSR_ANGLE_WINDOW:  cfg_in.angle_window  = csr_wdata[17:0];
         CSR_CART_LIMIT:    cfg_in.cart_limit    = csr_wdata;
         default:           cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wen) begin
         cfg_ff <= cfg_in;
      end
   end

   pcsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .last_item (req_data.last_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pcsb_datapath u_datapath (
      .clock    (clock),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
